// File: design/ordered_list_with_position_delete_macros.svh
// assertion macros for the ordered list block
`ifndef ORDERED_LIST_WITH_POSITION_DELETE_MACROS_SVH
`define ORDERED_LIST_WITH_POSITION_DELETE_MACROS_SVH

// property checked on every clock edge outside reset
`define OLPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define OLPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/olpd_pkg.sv
// shared types and constants for the ordered list block
`timescale 1ns / 1ps
`default_nettype none

package olpd_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // operation codes carried in s_tuser
    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_DEL_FRONT = 3'd1,
        FN_DEL_POS   = 3'd2,
        FN_INS_REAR  = 3'd3,
        FN_DEL_REAR  = 3'd4,
        FN_LIST      = 3'd5
    } func_t;

    // result status carried in m_tuser
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } state_t;

    // per-cycle move applied to the whole cell row
    typedef enum logic [2:0] {
        CH_HOLD      = 3'd0,
        CH_INS_FRONT = 3'd1,
        CH_INS_REAR  = 3'd2,
        CH_DEL       = 3'd3,
        CH_ROT       = 3'd4
    } chain_op_t;

    // broadcast from controller to every cell
    typedef struct packed {
        chain_op_t          op;
        logic [CNT_W-1:0]   idx;
        logic [DATA_W-1:0]  item;
    } chain_ctrl_t;

endpackage

`default_nettype wire

// File: design/olpd_cell.sv
// one storage cell of the list row
`timescale 1ns / 1ps
`default_nettype none

module olpd_cell (
    input  wire logic                         aclk,
    input  wire logic [olpd_pkg::CNT_W-1:0]   cell_idx,
    input  wire olpd_pkg::chain_ctrl_t        ch,
    input  wire logic [olpd_pkg::DATA_W-1:0]  left_val,
    input  wire logic [olpd_pkg::DATA_W-1:0]  right_val,
    input  wire logic [olpd_pkg::DATA_W-1:0]  first_val,
    output logic [olpd_pkg::DATA_W-1:0]       val_o,
    output logic [olpd_pkg::DATA_W-1:0]       rd_o
);

    logic [olpd_pkg::DATA_W-1:0] val_reg;
    logic [olpd_pkg::DATA_W-1:0] val_next;

    // next value for this cycle's move: neighbor, item or front
    always_comb begin
        val_next = val_reg;
        case (ch.op)
            olpd_pkg::CH_INS_FRONT: val_next = left_val;
            olpd_pkg::CH_INS_REAR: begin
                if (cell_idx == ch.idx) val_next = ch.item;
            end
            olpd_pkg::CH_DEL: begin
                if (cell_idx >= ch.idx) val_next = right_val;
            end
            olpd_pkg::CH_ROT: begin
                if (cell_idx == ch.idx) val_next = first_val;
                else if (cell_idx < ch.idx) val_next = right_val;
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    // value offered to the read tree when this cell is addressed
    assign val_o = val_reg;
    assign rd_o  = (cell_idx == ch.idx) ? val_reg : '0;

endmodule

`default_nettype wire

// File: design/olpd_ctrl.sv
// operation decode, item count and result register
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_with_position_delete_macros.svh"

module olpd_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [2:0]                   s_func,
    input  wire logic [olpd_pkg::DATA_W-1:0]  s_item,
    input  wire logic [olpd_pkg::POS_W-1:0]   s_position,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [olpd_pkg::DATA_W-1:0]       m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast,
    output olpd_pkg::chain_ctrl_t             ch,
    input  wire logic [olpd_pkg::DATA_W-1:0]  rd_value,
    input  wire logic [olpd_pkg::DATA_W-1:0]  first_value
);

    localparam logic [olpd_pkg::CNT_W-1:0] FULL_CNT = olpd_pkg::CNT_W'(olpd_pkg::DEPTH);
    localparam logic [olpd_pkg::CNT_W-1:0] ONE      = olpd_pkg::CNT_W'(1);

    olpd_pkg::state_t            state_reg, state_next;
    logic [olpd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [olpd_pkg::CNT_W-1:0]  remain_reg, remain_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [olpd_pkg::DATA_W-1:0] m_tdata_reg, m_tdata_next;
    olpd_pkg::status_t           m_tuser_reg, m_tuser_next;
    logic                        m_tlast_reg, m_tlast_next;
    logic                        out_free;
    logic                        s_beat;
    logic                        pos_bad;
    logic                        ins_full;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == olpd_pkg::S_IDLE) && out_free;
    assign s_beat   = s_tvalid && s_tready;
    assign pos_bad  = (s_position == '0) ||
                      (s_position > olpd_pkg::POS_W'(count_reg));

    // insert beat taken while the list is full
    assign ins_full = s_beat && (count_reg == FULL_CNT) &&
                      ((s_func == olpd_pkg::FN_INS_FRONT) ||
                       (s_func == olpd_pkg::FN_INS_REAR));

    // next state, chain move and result beat
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ch.op         = olpd_pkg::CH_HOLD;
        ch.idx        = '0;
        ch.item       = s_item;

        unique case (state_reg)
            olpd_pkg::S_IDLE: begin
                if (s_beat) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = olpd_pkg::ST_OK;
                    unique case (s_func)
                        olpd_pkg::FN_INS_FRONT, olpd_pkg::FN_INS_REAR: begin
                            if (count_reg == FULL_CNT) begin
                                m_tuser_next = olpd_pkg::ST_FULL;
                            end else begin
                                ch.op      = (s_func == olpd_pkg::FN_INS_FRONT) ?
                                             olpd_pkg::CH_INS_FRONT : olpd_pkg::CH_INS_REAR;
                                ch.idx     = count_reg;
                                count_next = count_reg + ONE;
                            end
                        end
                        olpd_pkg::FN_DEL_FRONT, olpd_pkg::FN_DEL_REAR: begin
                            if (count_reg == '0) begin
                                m_tuser_next = olpd_pkg::ST_EMPTY;
                            end else begin
                                ch.op        = olpd_pkg::CH_DEL;
                                ch.idx       = (s_func == olpd_pkg::FN_DEL_FRONT) ?
                                               '0 : count_reg - ONE;
                                m_tdata_next = rd_value;
                                count_next   = count_reg - ONE;
                            end
                        end
                        olpd_pkg::FN_DEL_POS: begin
                            if (count_reg == '0) begin
                                m_tuser_next = olpd_pkg::ST_EMPTY;
                            end else if (pos_bad) begin
                                m_tuser_next = olpd_pkg::ST_INVALID;
                            end else begin
                                ch.op        = olpd_pkg::CH_DEL;
                                ch.idx       = olpd_pkg::CNT_W'(s_position - 1'b1);
                                m_tdata_next = rd_value;
                                count_next   = count_reg - ONE;
                            end
                        end
                        olpd_pkg::FN_LIST: begin
                            if (count_reg == '0) begin
                                m_tuser_next = olpd_pkg::ST_EMPTY;
                            end else begin
                                m_tvalid_next = 1'b0;
                                state_next    = olpd_pkg::S_LIST;
                                remain_next   = count_reg;
                            end
                        end
                        default: begin
                            // unused codes: no result
                            m_tvalid_next = 1'b0;
                        end
                    endcase
                end
            end
            olpd_pkg::S_LIST: begin
                // emit the front item and rotate it to the rear
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = first_value;
                    m_tuser_next  = olpd_pkg::ST_OK;
                    m_tlast_next  = (remain_reg == ONE);
                    ch.op         = olpd_pkg::CH_ROT;
                    ch.idx        = count_reg - ONE;
                    remain_next   = remain_reg - ONE;
                    if (remain_reg == ONE) state_next = olpd_pkg::S_IDLE;
                end
            end
            default: state_next = olpd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= olpd_pkg::S_IDLE;
            count_reg    <= '0;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            remain_reg   <= remain_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `OLPD_ASSERT(a_count_bound, count_reg <= FULL_CNT, "item count above depth")
    `OLPD_ASSERT(a_list_count_stable, (state_reg == olpd_pkg::S_LIST) |=> $stable(count_reg), "count moved during list")
    `OLPD_ASSERT(a_full_no_grow, ins_full |=> $stable(count_reg), "count grew past full")
    `OLPD_ASSERT(a_empty_is_last, (m_tvalid_reg && m_tuser_reg == olpd_pkg::ST_EMPTY) |-> m_tlast_reg, "empty status not last")
    `OLPD_ASSERT_ALWAYS(a_list_nonzero, (state_reg == olpd_pkg::S_LIST) |-> (remain_reg != '0), "list with nothing left")

endmodule

`default_nettype wire

// File: design/ordered_list_with_position_delete.sv
// Ordered list of up to DEPTH (16) signed 32-bit items held in a row of cells, front at
// cell 0. Each input beat carries an operation in s_tuser and the item and 1-based
// position in s_tdata. An insert or delete moves the row in the accept cycle: a front
// insert shifts it one cell, a delete shifts the cells from the deleted one on, a rear
// insert writes the cell after the last item. The result beat is registered, so a new
// beat is taken every cycle while results are drained. A list operation rotates the
// row once per emitted beat through the front cell; no input is taken until the last
// item is in the output register. All but unused codes 6 and 7 end on an m_tlast beat.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_with_position_delete (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // item [31:0], position [47:32]
    input  wire logic [2:0]  s_tuser,   // func [2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // value [31:0]
    output logic [1:0]       m_tuser,   // status [1:0]
    output logic             m_tlast
);

    olpd_pkg::chain_ctrl_t       ch;
    logic [olpd_pkg::DATA_W-1:0] cell_val [olpd_pkg::DEPTH];
    logic [olpd_pkg::DATA_W-1:0] cell_rd  [olpd_pkg::DEPTH];
    logic [olpd_pkg::DATA_W-1:0] left_in  [olpd_pkg::DEPTH];
    logic [olpd_pkg::DATA_W-1:0] right_in [olpd_pkg::DEPTH];
    logic [olpd_pkg::DATA_W-1:0] rd_value;

    // controller
    olpd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_func      (s_tuser),
        .s_item      (s_tdata[31:0]),
        .s_position  (s_tdata[47:32]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .ch          (ch),
        .rd_value    (rd_value),
        .first_value (cell_val[0])
    );

    // row of cells, each wired to its neighbors
    for (genvar i = 0; i < olpd_pkg::DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign left_in[i] = ch.item;
        end else begin : g_mid
            assign left_in[i] = cell_val[i-1];
        end
        if (i == olpd_pkg::DEPTH - 1) begin : g_tail
            assign right_in[i] = '0;
        end else begin : g_body
            assign right_in[i] = cell_val[i+1];
        end

        olpd_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (olpd_pkg::CNT_W'(i)),
            .ch        (ch),
            .left_val  (left_in[i]),
            .right_val (right_in[i]),
            .first_val (cell_val[0]),
            .val_o     (cell_val[i]),
            .rd_o      (cell_rd[i])
        );
    end

    // or-combine the addressed cell onto the read bus
    always_comb begin
        rd_value = '0;
        for (int k = 0; k < olpd_pkg::DEPTH; k++) begin
            rd_value = rd_value | cell_rd[k];
        end
    end

endmodule

`default_nettype wire
